@@ design/ic_pkg.sv @@
// Package for the interleave checker: commands, sequencer states and the cell link type.
package ic_pkg;

  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_LOAD_TARGET = 2'd2;
  localparam logic [1:0] CMD_EVALUATE    = 2'd3;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // What one cell hands to the next: row valid, the first-string byte of that row
  // and the cell's freshly computed table bit.
  typedef struct packed {
    logic       vld;
    logic [7:0] a;
    logic       dp;
  } link_t;

endpackage

@@ design/ic_in_if.sv @@
// Input channel interface: command and character with valid/ready.
interface ic_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_value;

  modport source (output valid, output cmd, output char_value, input ready);
  modport sink (input valid, input cmd, input char_value, output ready);
endinterface

@@ design/ic_out_if.sv @@
// Output channel interface: the three result flags with valid/ready.
interface ic_out_if;
  logic valid;
  logic ready;
  logic interleaved;
  logic length_match;
  logic overflow;

  modport source (output valid, output interleaved, output length_match, output overflow,
                  input ready);
  modport sink (input valid, input interleaved, input length_match, input overflow,
                output ready);
endinterface

@@ design/interleave_check.sv @@
// Interleave checker top level: string stores, sequencer and the chain of table cells.
//
// Usage: items arrive on the inp channel. A command of load first, load second or
// load target appends char_value to that string; each load is one transaction and gives
// no result. An evaluate transaction produces exactly one result
// transaction on the out channel carrying interleaved, length_match and overflow.
// Loads beyond capacity (MAX_LEN for the first two strings, 2*MAX_LEN for the target)
// are dropped and flag overflow. After an evaluate all counts and the flag are cleared.
// An evaluate with overflow or a length mismatch answers on the next cycle.
// Otherwise the cells run as a wavefront, cell j handling row i at step i+j, and the
// answer is registered when the walk ends. The length of that walk is set by the first
// and second string lengths, one anti-diagonal of the table per cycle, with one target
// byte broadcast to all cells.
// Throughput: one item at a time; inp.ready is low during an evaluation and while a
// result waits on the output register, so a stalled receiver holds off new input.
// Reset (rst, synchronous) clears the counts, the overflow flag, the sequencer and the
// output valid; the string stores keep whatever they held and need no clearing pass.
module interleave_check
  import ic_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  logic      clk,
  input  logic      rst,
  ic_in_if.sink     inp,
  ic_out_if.source  out
);

  localparam int FAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TAW = $clog2(2 * MAX_LEN);
  localparam int FCW = $clog2(MAX_LEN + 1);
  localparam int TCW = $clog2(2 * MAX_LEN + 2);

  // String stores; the second string lives inside the cells.
  logic [7:0] first_mem  [MAX_LEN];
  logic [7:0] target_mem [2 * MAX_LEN];

  logic [FCW-1:0] first_count, second_count;
  logic [TCW-1:0] target_count;
  logic           overflow_flag;

  logic           state;
  logic [TCW-1:0] tau;
  logic [FCW-1:0] n1, n2;
  logic [TCW-1:0] stop;

  logic [7:0] first_q, t_q;

  logic dp0, vld0;
  logic [7:0] a0;
  link_t links [MAX_LEN + 1];
  logic [MAX_LEN:0] dp_vec;

  logic out_vld, res_il, res_lm, res_ov;

  logic acc, is_load1, is_load2, is_load3, is_eval, match, clr;

  assign inp.ready = (state == ST_IDLE) && !out_vld;
  assign acc       = inp.valid && inp.ready;
  assign is_load1  = acc && (inp.cmd == CMD_LOAD_FIRST);
  assign is_load2  = acc && (inp.cmd == CMD_LOAD_SECOND);
  assign is_load3  = acc && (inp.cmd == CMD_LOAD_TARGET);
  assign is_eval   = acc && (inp.cmd == CMD_EVALUATE);
  assign match     = target_count == (TCW'(first_count) + TCW'(second_count));
  // Starting a table walk clears every cell's row bit.
  assign clr       = is_eval && match && !overflow_flag;
  assign stop      = TCW'(n1) + TCW'(n2) + TCW'(1);

  // Memory writes and registered reads; the read address follows the step counter so
  // that step tau sees target byte tau-1 and first-string byte tau-1.
  always_ff @(posedge clk) begin
    if (is_load1 && (first_count < FCW'(MAX_LEN))) begin
      first_mem[first_count[FAW-1:0]] <= inp.char_value;
    end
    if (is_load3 && (target_count < TCW'(2 * MAX_LEN))) begin
      target_mem[target_count[TAW-1:0]] <= inp.char_value;
    end
    first_q <= first_mem[tau[FAW-1:0]];
    t_q     <= target_mem[tau[TAW-1:0]];
  end

  // Counts, overflow and the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count   <= '0;
      second_count  <= '0;
      target_count  <= '0;
      overflow_flag <= 1'b0;
      state         <= ST_IDLE;
      tau           <= '0;
      out_vld       <= 1'b0;
    end else begin
      if (out_vld && out.ready) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          tau <= '0;
          if (is_load1) begin
            if (first_count < FCW'(MAX_LEN)) first_count <= first_count + FCW'(1);
            else overflow_flag <= 1'b1;
          end
          if (is_load2) begin
            if (second_count < FCW'(MAX_LEN)) second_count <= second_count + FCW'(1);
            else overflow_flag <= 1'b1;
          end
          if (is_load3) begin
            if (target_count < TCW'(2 * MAX_LEN)) target_count <= target_count + TCW'(1);
            else overflow_flag <= 1'b1;
          end
          if (is_eval) begin
            n1            <= first_count;
            n2            <= second_count;
            first_count   <= '0;
            second_count  <= '0;
            target_count  <= '0;
            overflow_flag <= 1'b0;
            if (clr) begin
              state <= ST_RUN;
            end else begin
              out_vld <= 1'b1;
              res_il  <= 1'b0;
              res_lm  <= match;
              res_ov  <= overflow_flag;
            end
          end
        end
        ST_RUN: begin
          tau <= tau + TCW'(1);
          if (tau == stop) begin
            state   <= ST_IDLE;
            out_vld <= 1'b1;
            res_il  <= dp_vec[n2];
            res_lm  <= 1'b1;
            res_ov  <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Cell zero: the table's first column, fed the first string one row per step.
  always_ff @(posedge clk) begin
    a0 <= first_q;
    if (rst || clr) begin
      vld0 <= 1'b0;
      dp0  <= 1'b0;
    end else begin
      vld0 <= (state == ST_RUN) && (tau <= TCW'(n1));
      if ((state == ST_RUN) && (tau <= TCW'(n1))) begin
        if (tau == '0) dp0 <= 1'b1;
        else           dp0 <= dp0 && (first_q == t_q);
      end
    end
  end

  assign links[0]  = '{vld: vld0, a: a0, dp: dp0};
  assign dp_vec[0] = dp0;

  for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
    ic_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .clr        (clr),
      .ld         (is_load2 && (second_count == FCW'(j - 1))),
      .char_value (inp.char_value),
      .t_char     (t_q),
      .left       (links[j-1]),
      .right      (links[j])
    );
    assign dp_vec[j] = links[j].dp;
  end

  assign out.valid        = out_vld;
  assign out.interleaved  = res_il;
  assign out.length_match = res_lm;
  assign out.overflow     = res_ov;

endmodule

@@ design/ic_cell.sv @@
// One table cell: holds a second-string byte and one bit of the rolling row.
module ic_cell
  import ic_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       clr,
  input  logic       ld,
  input  logic [7:0] char_value,
  input  logic [7:0] t_char,
  input  link_t      left,
  output link_t      right
);

  logic [7:0] s;
  logic       dp;
  logic       vld;
  logic [7:0] a;

  always_ff @(posedge clk) begin
    if (ld) begin
      s <= char_value;
    end
    a <= left.a;
    if (rst || clr) begin
      vld <= 1'b0;
      dp  <= 1'b0;
    end else begin
      vld <= left.vld;
      if (left.vld) begin
        dp <= (dp && (left.a == t_char)) || (left.dp && (s == t_char));
      end
    end
  end

  assign right = '{vld: vld, a: a, dp: dp};

endmodule

@@ design/ic_check.sv @@
// Port-level checker for the interleave checker, bound to the top level.
module ic_check (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic interleaved,
  input logic length_match,
  input logic overflow
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(interleaved))
    else $error("result dropped or changed while stalled");

  a_il_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && interleaved |-> length_match && !overflow)
    else $error("interleaved without matching lengths or with overflow");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a result waits");

endmodule

bind interleave_check ic_check u_ic_check (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (inp.ready),
  .out_valid    (out.valid),
  .out_ready    (out.ready),
  .interleaved  (out.interleaved),
  .length_match (out.length_match),
  .overflow     (out.overflow)
);
